>>> rtl/ctosd_pkg.sv
`timescale 1ns / 1ps
package ctosd_pkg;

   // frame and layout
   localparam int DEF_FRAME_HEIGHT = 360;
   localparam logic [9:0] TEXT_X = 10'd20;
   localparam logic [9:0] LINE1_Y = 10'd220;
   localparam logic [9:0] LINE2_Y = LINE1_Y + 10'd48 + 10'd10;
   localparam logic [9:0] LINE3_Y = LINE2_Y + 10'd16 + 10'd5;
   localparam logic [9:0] LINE1_W = 10'd120;
   localparam logic [9:0] LINE2_W = 10'd64;
   localparam logic [9:0] LINE3_W = 10'd88;
   // line three: half-day pair ends at 32, weekday words start after an 8-pixel space
   localparam logic [9:0] LINE3_SPACE_X = 10'd32;
   localparam logic [9:0] LINE3_WEEK_X = 10'd40;
   localparam logic [7:0] DIV3_MUL = 8'd171;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_HOUR    = 3'd0,
      CSR_MINUTE  = 3'd1,
      CSR_MONTH   = 3'd2,
      CSR_DAY     = 3'd3,
      CSR_WEEKDAY = 3'd4,
      CSR_WIDTH   = 3'd5
   } csr_index_type;

   // result classes
   typedef enum logic [1:0] {
      HIT_NONE   = 2'd0,
      HIT_TEXT   = 2'd1,
      HIT_SHADOW = 2'd2
   } hit_type;

   // glyph codes: digits 0..9, colon, then the hanzi
   localparam logic [4:0] G_COLON  = 5'd10;
   localparam logic [4:0] G_HZ     = 5'd11;
   localparam logic [4:0] G_AM     = 5'd11;
   localparam logic [4:0] G_PM     = 5'd12;
   localparam logic [4:0] G_WU     = 5'd13;
   localparam logic [4:0] G_XING   = 5'd14;
   localparam logic [4:0] G_QI     = 5'd15;
   localparam logic [4:0] G_SUNDAY = 5'd22;
   localparam logic [4:0] G_MONTH  = 5'd23;
   localparam logic [4:0] G_DAY    = 5'd24;

   typedef struct packed {
      logic [2:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] min_tens;
      logic [3:0] min_ones;
      logic [2:0] mon_tens;
      logic [3:0] mon_ones;
      logic       mon_two;
      logic [2:0] day_tens;
      logic [3:0] day_ones;
      logic       day_two;
      logic       pm;
      logic [4:0] wd_glyph;
   } digits_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] glyph;
      logic [3:0] row;
      logic [3:0] col;
   } locate_type;

   localparam logic [7:0] DIGIT_ROM [11][16] = '{
      '{8'h00,8'h00,8'h00,8'h1C,8'h36,8'h63,8'h63,8'h63,8'h63,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h0C,8'h3C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3E,8'h63,8'h63,8'h63,8'h03,8'h06,8'h0C,8'h18,8'h30,8'h63,8'h7F,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3E,8'h63,8'h63,8'h03,8'h06,8'h1C,8'h06,8'h03,8'h63,8'h63,8'h3E,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h06,8'h0E,8'h0E,8'h1E,8'h36,8'h36,8'h66,8'h7F,8'h06,8'h06,8'h1F,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h7F,8'h60,8'h60,8'h60,8'h7C,8'h66,8'h03,8'h03,8'h63,8'h66,8'h3C,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h1C,8'h36,8'h60,8'h60,8'h7E,8'h73,8'h63,8'h63,8'h63,8'h33,8'h1E,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h7F,8'h63,8'h06,8'h06,8'h0C,8'h0C,8'h18,8'h18,8'h18,8'h18,8'h18,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3E,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h36,8'h63,8'h63,8'h63,8'h3E,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3C,8'h66,8'h63,8'h63,8'h63,8'h67,8'h3F,8'h03,8'h03,8'h36,8'h1C,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h18,8'h18,8'h00,8'h00,8'h00,8'h00,8'h18,8'h18,8'h00,8'h00,8'h00,8'h00}
   };

   localparam logic [15:0] HANZI_ROM [14][16] = '{
      '{16'h0300,16'h0300,16'h0300,16'h0300,16'h0300,16'h0300,16'h03FC,16'h0300,
        16'h0300,16'h0300,16'h0300,16'h0300,16'h0300,16'h0300,16'hFFFF,16'h0000},
      '{16'h0000,16'hFFFF,16'h0300,16'h0300,16'h0300,16'h0300,16'h0360,16'h0330,
        16'h0318,16'h030C,16'h030C,16'h0300,16'h0300,16'h0300,16'h0300,16'h0300},
      '{16'h0C00,16'h0C00,16'h0C00,16'h1FFC,16'h1980,16'h3180,16'h6180,16'h0180,
        16'h0180,16'hFFFF,16'h0180,16'h0180,16'h0180,16'h0180,16'h0180,16'h0180},
      '{16'h0000,16'h1FF8,16'h1818,16'h1FF8,16'h1818,16'h1FF8,16'h0180,16'h1980,
        16'h1FFC,16'h3180,16'h6180,16'h1FF8,16'h0180,16'h0180,16'h7FFE,16'h0000},
      '{16'h3300,16'h337E,16'h7FE6,16'h3366,16'h3366,16'h3F7E,16'h3366,16'h3366,
        16'h3F66,16'h337E,16'h3366,16'hFFE6,16'h06C6,16'h33C6,16'h619E,16'hC30C},
      '{16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'hFFFF,
        16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'h0000,16'h3FFC,16'h0000,16'h0000,16'h0000,16'h0000,
        16'h0000,16'h0000,16'h0000,16'h0000,16'hFFFF,16'h0000,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'h7FFE,16'h0000,16'h0000,16'h0000,16'h0000,16'h3FFC,
        16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'hFFFF,16'h0000,16'h0000},
      '{16'h0000,16'h0000,16'h7FFE,16'h6666,16'h6666,16'h6666,16'h6666,16'h6666,
        16'h6C66,16'h6C3E,16'h7806,16'h7006,16'h6006,16'h7FFE,16'h6006,16'h0000},
      '{16'h0000,16'h7FFE,16'h0300,16'h0300,16'h0300,16'h0300,16'h3FF8,16'h0618,
        16'h0618,16'h0618,16'h0618,16'h0C18,16'h0C18,16'h0C18,16'hFFFF,16'h0000},
      '{16'h0300,16'h0180,16'h00C0,16'h00C0,16'h0000,16'hFFFF,16'h0000,16'h0000,
        16'h0660,16'h0630,16'h0C18,16'h0C0C,16'h180C,16'h3006,16'h6006,16'h0000},
      '{16'h0000,16'h3FFC,16'h0180,16'h0180,16'h0180,16'h0180,16'hFFFF,16'h0180,
        16'h03C0,16'h03C0,16'h0660,16'h0660,16'h0C30,16'h1818,16'h300C,16'hE007},
      '{16'h0000,16'h1FFC,16'h180C,16'h180C,16'h180C,16'h1FFC,16'h180C,16'h180C,
        16'h180C,16'h1FFC,16'h180C,16'h180C,16'h300C,16'h300C,16'h603C,16'hC018},
      '{16'h0000,16'h1FF8,16'h1818,16'h1818,16'h1818,16'h1818,16'h1818,16'h1FF8,
        16'h1818,16'h1818,16'h1818,16'h1818,16'h1818,16'h1818,16'h1FF8,16'h1818}
   };

   // tens and ones of a value below 64 by repeated subtraction
   function automatic logic [6:0] dec_split(input logic [5:0] v);
      logic [5:0] r;
      logic [2:0] t;
      r = v;
      t = 3'd0;
      for (int i = 0; i < 6; i++) begin
         if (r >= 6'd10) begin
            r = r - 6'd10;
            t = t + 3'd1;
         end
      end
      return {t, r[3:0]};
   endfunction

endpackage

>>> rtl/ctosd_if.sv
`timescale 1ns / 1ps
interface ctosd_req_if;
   logic        valid;
   logic        ready;
   logic [9:0]  pixel_x;
   logic [9:0]  pixel_y;
   logic [15:0] background_pixel;
   modport source (output valid, pixel_x, pixel_y, background_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, background_pixel, output ready);
endinterface

interface ctosd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_out;
   logic [1:0]  overlay_hit;
   modport source (output valid, pixel_out, overlay_hit, input ready);
   modport sink (input valid, pixel_out, overlay_hit, output ready);
endinterface

>>> rtl/ctosd_locate.sv
`timescale 1ns / 1ps
module ctosd_locate #(
   parameter int OFFSET = 0
) (
   input  logic [9:0]              px,
   input  logic [9:0]              py,
   input  ctosd_pkg::digits_type   digits,
   output ctosd_pkg::locate_type   loc
);
   import ctosd_pkg::*;

   logic [10:0] xs, ys;
   logic [9:0]  xv, yv, dx, dy1;
   logic [13:0] row_prod;
   logic [14:0] col_prod;
   logic [5:0]  q;
   logic [3:0]  u, mn, hz_m, dst, dn, hz_d, lim;
   logic [9:0]  dy2, dy3, dw;

   // shifted point, negative coordinates never hit
   assign xs = {1'b0, px} - 11'(OFFSET);
   assign ys = {1'b0, py} - 11'(OFFSET);
   assign xv = xs[9:0];
   assign yv = ys[9:0];
   assign dx = xv - TEXT_X;
   assign dy1 = yv - LINE1_Y;
   assign dy2 = yv - LINE2_Y;
   assign dy3 = yv - LINE3_Y;
   assign dw = dx - LINE3_WEEK_X;

   // divide by the scale of three through a reciprocal
   assign row_prod = dy1[5:0] * DIV3_MUL;
   assign col_prod = dx[6:0] * DIV3_MUL;
   assign q = col_prod[14:9];

   // second line cursor positions in 8-pixel units
   assign u = {1'b0, dx[5:3]};
   assign mn = digits.mon_two ? 4'd2 : 4'd1;
   assign dn = digits.day_two ? 4'd2 : 4'd1;
   assign hz_m = mn;
   assign dst = mn + 4'd2;
   assign hz_d = dst + dn;
   assign lim = hz_d + 4'd2;

   always_comb begin
      loc = '0;
      if (!xs[10] && !ys[10] && xv >= TEXT_X) begin
         // line one: big time digits
         if (yv >= LINE1_Y && dy1 < 10'd48 && dx < LINE1_W) begin
            loc.hit = 1'b1;
            loc.row = row_prod[12:9];
            loc.col = {1'b0, q[2:0]};
            case (q[5:3])
               3'd0: loc.glyph = {2'b0, digits.hour_tens};
               3'd1: loc.glyph = {1'b0, digits.hour_ones};
               3'd2: loc.glyph = G_COLON;
               3'd3: loc.glyph = {2'b0, digits.min_tens};
               default: loc.glyph = {1'b0, digits.min_ones};
            endcase
         end
         // line two: month and day
         else if (yv >= LINE2_Y && dy2 < 10'd16 && dx < LINE2_W && u < lim) begin
            loc.hit = 1'b1;
            loc.row = dy2[3:0];
            loc.col = {1'b0, dx[2:0]};
            if (u < hz_m) begin
               loc.glyph = (digits.mon_two && u == 4'd0) ?
                  {2'b0, digits.mon_tens} : {1'b0, digits.mon_ones};
            end else if (u < dst) begin
               loc.glyph = G_MONTH;
               loc.col = {u[0] ^ hz_m[0], dx[2:0]};
            end else if (u < hz_d) begin
               loc.glyph = (digits.day_two && u == dst) ?
                  {2'b0, digits.day_tens} : {1'b0, digits.day_ones};
            end else begin
               loc.glyph = G_DAY;
               loc.col = {u[0] ^ hz_d[0], dx[2:0]};
            end
         end
         // line three: half day, space, then weekday
         else if (yv >= LINE3_Y && dy3 < 10'd16 && dx < LINE3_W) begin
            loc.hit = 1'b1;
            loc.row = dy3[3:0];
            if (dx < LINE3_SPACE_X) begin
               loc.col = dx[3:0];
               loc.glyph = dx[4] ? G_WU : (digits.pm ? G_PM : G_AM);
            end else if (dx < LINE3_WEEK_X) begin
               loc.hit = 1'b0;
            end else begin
               loc.col = dw[3:0];
               case (dw[5:4])
                  2'd0: loc.glyph = G_XING;
                  2'd1: loc.glyph = G_QI;
                  default: loc.glyph = digits.wd_glyph;
               endcase
            end
         end
      end
   end

endmodule

>>> rtl/ctosd_font_rom.sv
`timescale 1ns / 1ps
module ctosd_font_rom (
   input  logic        clock,
   input  logic        enable,
   input  logic [4:0]  glyph_a,
   input  logic [3:0]  row_a,
   input  logic [4:0]  glyph_b,
   input  logic [3:0]  row_b,
   output logic [15:0] data_a,
   output logic [15:0] data_b
);
   import ctosd_pkg::*;

   logic [15:0] data_a_ff, data_b_ff;
   logic [4:0]  hz_a, hz_b;

   assign hz_a = glyph_a - G_HZ;
   assign hz_b = glyph_b - G_HZ;

   // two registered read ports; digits sit in the left byte of the row
   always_ff @(posedge clock) begin
      if (enable) begin
         if (glyph_a < G_HZ) data_a_ff <= {DIGIT_ROM[glyph_a[3:0]][row_a], 8'h00};
         else if (hz_a < 5'd14) data_a_ff <= HANZI_ROM[hz_a[3:0]][row_a];
         else data_a_ff <= 16'h0000;
         if (glyph_b < G_HZ) data_b_ff <= {DIGIT_ROM[glyph_b[3:0]][row_b], 8'h00};
         else if (hz_b < 5'd14) data_b_ff <= HANZI_ROM[hz_b[3:0]][row_b];
         else data_b_ff <= 16'h0000;
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

>>> rtl/clock_text_osd_overlay.sv
`timescale 1ns / 1ps
// each accepted pixel passes the stage-one and font rom registers, then the output register
// throughput: one pixel per clock, set by the two-port registered font rom
// the whole pipe stalls only while a finished result waits for the sink
// reset (synchronous, active high) clears the pipe and loads the register
// defaults: 0:00, month 1, day 1, sunday, frame width 360
module clock_text_osd_overlay #(
   parameter int FRAME_HEIGHT = ctosd_pkg::DEF_FRAME_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   ctosd_req_if.sink   req_chan,
   ctosd_rsp_if.source rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import ctosd_pkg::*;

   localparam logic [9:0] HEIGHT_LIMIT = 10'(FRAME_HEIGHT);

   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [2:0]  weekday_ff;
   logic [9:0]  width_ff;
   digits_type  digits;
   logic [6:0]  hour_dec, min_dec, mon_dec, day_dec;
   locate_type  loc_text, loc_shadow;
   logic        advance;
   logic        s1_valid_ff, s1_frame_ff, s1_hit_a_ff, s1_hit_b_ff;
   logic [3:0]  s1_col_a_ff, s1_col_b_ff;
   logic [15:0] s1_bg_ff, rom_a, rom_b;
   logic        rsp_valid_ff;
   logic [15:0] rsp_pixel_ff, rsp_pixel_in;
   logic [1:0]  rsp_hit_ff, rsp_hit_in;
   logic        text_on, shadow_on, in_frame;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff <= 5'd0;
         minute_ff <= 6'd0;
         month_ff <= 4'd1;
         day_ff <= 5'd1;
         weekday_ff <= 3'd0;
         width_ff <= 10'd360;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HOUR:    hour_ff <= csr_data[4:0];
            CSR_MINUTE:  minute_ff <= csr_data[5:0];
            CSR_MONTH:   month_ff <= csr_data[3:0];
            CSR_DAY:     day_ff <= csr_data[4:0];
            CSR_WEEKDAY: weekday_ff <= csr_data[2:0];
            CSR_WIDTH:   width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // decimal digits and glyph choices from the registers
   assign hour_dec = dec_split({1'b0, hour_ff});
   assign min_dec = dec_split(minute_ff);
   assign mon_dec = dec_split({2'b0, month_ff});
   assign day_dec = dec_split({1'b0, day_ff});

   always_comb begin
      digits.hour_tens = hour_dec[6:4];
      digits.hour_ones = hour_dec[3:0];
      digits.min_tens = min_dec[6:4];
      digits.min_ones = min_dec[3:0];
      digits.mon_tens = mon_dec[6:4];
      digits.mon_ones = mon_dec[3:0];
      digits.mon_two = (mon_dec[6:4] != 3'd0);
      digits.day_tens = day_dec[6:4];
      digits.day_ones = day_dec[3:0];
      digits.day_two = (day_dec[6:4] != 3'd0);
      digits.pm = (hour_ff >= 5'd12);
      digits.wd_glyph = (weekday_ff >= 3'd1 && weekday_ff <= 3'd6) ?
         (G_QI + {2'b0, weekday_ff}) : G_SUNDAY;
   end

   // glyph lookup for the pixel and for its shadow source
   ctosd_locate #(.OFFSET(0)) u_loc_text (
      .px(req_chan.pixel_x), .py(req_chan.pixel_y), .digits(digits), .loc(loc_text)
   );

   ctosd_locate #(.OFFSET(2)) u_loc_shadow (
      .px(req_chan.pixel_x), .py(req_chan.pixel_y), .digits(digits), .loc(loc_shadow)
   );

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign in_frame = (req_chan.pixel_y < HEIGHT_LIMIT) && (req_chan.pixel_x < width_ff);

   ctosd_font_rom u_rom (
      .clock(clock), .enable(advance),
      .glyph_a(loc_text.glyph), .row_a(loc_text.row),
      .glyph_b(loc_shadow.glyph), .row_b(loc_shadow.row),
      .data_a(rom_a), .data_b(rom_b)
   );

   // stage one: rom read in flight
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_chan.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_frame_ff <= in_frame;
         s1_hit_a_ff <= loc_text.hit;
         s1_hit_b_ff <= loc_shadow.hit;
         s1_col_a_ff <= loc_text.col;
         s1_col_b_ff <= loc_shadow.col;
         s1_bg_ff <= req_chan.background_pixel;
      end
   end

   // stage two: bit pick and mix
   assign text_on = s1_frame_ff && s1_hit_a_ff && rom_a[~s1_col_a_ff];
   assign shadow_on = s1_frame_ff && s1_hit_b_ff && rom_b[~s1_col_b_ff];

   always_comb begin
      if (text_on) begin
         rsp_pixel_in = 16'hFFFF;
         rsp_hit_in = HIT_TEXT;
      end else if (shadow_on) begin
         rsp_pixel_in = 16'h0000;
         rsp_hit_in = HIT_SHADOW;
      end else begin
         rsp_pixel_in = s1_bg_ff;
         rsp_hit_in = HIT_NONE;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pixel_ff;
   assign rsp_chan.overlay_hit = rsp_hit_ff;

`ifndef ASSERT_OFF
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff |=> rsp_valid_ff)
      else $error("stage one item lost");

   a_outside_frame: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && !s1_frame_ff |=> rsp_hit_ff == HIT_NONE)
      else $error("pixel outside frame was drawn");

   a_class_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff != HIT_NONE |->
         (rsp_hit_ff == HIT_TEXT && rsp_pixel_ff == 16'hFFFF) ||
         (rsp_hit_ff == HIT_SHADOW && rsp_pixel_ff == 16'h0000))
      else $error("result class and color disagree");
`endif

endmodule
